// ----- design/dfalex_pkg.sv -----
`timescale 1ns / 1ps

package dfalex_pkg;

    localparam int POS_W  = 22;
    localparam int CHAR_W = 8;
    localparam int WORD_W = 32;
    localparam int ADDR_W = 16;
    localparam int SIZE_W = 16;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CHAR  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        VERDICT_NOT_FOUND = 2'd0,
        VERDICT_FOUND     = 2'd1,
        VERDICT_ERROR     = 2'd2
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEST = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

// ----- design/dfa_lexicon_word_lookup.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: table_address, table_word, character;
//                                              tuser: operation; tlast: last_character
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: verdict
// cfg       in   cfg_wr_en                     cfg_wr_data: table_size
//
// A write transaction is taken in ST_IDLE. A character transaction reads the current
// state's entry, checks its destination in ST_DEST and scans the destination state's
// transitions in ST_SCAN, one table read per cycle; a word's last character then issues
// its verdict in ST_EMIT. After a rejection or fault, a character skips the table reads.
// Reset clears the walk state and table_size; the table memory is not cleared.
// The verdict waits in its state while the output register is still full.

module dfa_lexicon_word_lookup #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] table_address, [47:16] table_word, [55:48] character
    input  logic [dfalex_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] verdict, [7:2] zero
    output logic [dfalex_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_wr_en,
    input  logic [dfalex_pkg::SIZE_W-1:0]    cfg_wr_data
);
    import dfalex_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [POS_W:0] DEPTH_LIM = (POS_W + 1)'(TABLE_DEPTH);

    logic [WORD_W-1:0] mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [POS_W-1:0]  mem_raddr;
    logic [POS_W-1:0]  mem_waddr;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  cur_reg, cur_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              last_reg, last_next;
    logic              rej_reg, rej_next;
    logic              fault_reg, fault_next;
    logic              term_reg, term_next;
    logic [SIZE_W-1:0] table_size_reg;
    logic              out_valid_reg, out_valid_next;
    verdict_t          verdict_reg, verdict_next;

    logic [ADDR_W-1:0] in_addr;
    logic [WORD_W-1:0] in_word;
    logic [CHAR_W-1:0] in_char;
    logic              accept;
    logic              addr_ok;
    logic [POS_W-1:0]  rd_dest;
    logic [CHAR_W-1:0] rd_char;
    logic              rd_last;
    logic              rd_term;
    logic [POS_W-1:0]  pos_inc;
    logic              dest_bad;
    logic              inc_bad;

    assign in_addr = s_axis_tdata[15:0];
    assign in_word = s_axis_tdata[47:16];
    assign in_char = s_axis_tdata[55:48];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_waddr     = POS_W'(in_addr);
    assign addr_ok       = {1'b0, mem_waddr} < DEPTH_LIM;

    assign rd_dest = rdata_reg[22:1];
    assign rd_char = rdata_reg[30:23];
    assign rd_last = rdata_reg[0];
    assign rd_term = rdata_reg[31];
    assign pos_inc = pos_reg + POS_W'(1);

    assign dest_bad = ({1'b0, rd_dest} > (POS_W + 1)'(table_size_reg))
                   || ({1'b0, rd_dest} >= DEPTH_LIM);
    assign inc_bad  = ({1'b0, pos_inc} > (POS_W + 1)'(table_size_reg))
                   || ({1'b0, pos_inc} >= DEPTH_LIM);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(verdict_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr[AW-1:0]] <= in_word;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr[AW-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        rej_next       = rej_reg;
        fault_next     = fault_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        verdict_next   = verdict_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = cur_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(s_axis_tuser) == OP_WRITE)
                    begin
                        mem_we = addr_ok;
                    end
                    else
                    begin
                        ch_next   = in_char;
                        last_next = s_axis_tlast;
                        if (!rej_reg && !fault_reg)
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_DEST;
                        end
                        else
                        begin
                            state_next = s_axis_tlast ? ST_EMIT : ST_IDLE;
                        end
                    end
                end
            end
            ST_DEST:
            begin
                if (rd_dest == '0)
                begin
                    rej_next   = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else if (dest_bad)
                begin
                    fault_next = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    pos_next   = rd_dest;
                    mem_re     = 1'b1;
                    mem_raddr  = rd_dest;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_char == ch_reg)
                begin
                    cur_next   = pos_reg;
                    term_next  = rd_term;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else if (rd_last)
                begin
                    rej_next   = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else if (inc_bad)
                begin
                    fault_next = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    pos_next  = pos_inc;
                    mem_re    = 1'b1;
                    mem_raddr = pos_inc;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    if (fault_reg)
                    begin
                        verdict_next = VERDICT_ERROR;
                    end
                    else if (rej_reg || !term_reg)
                    begin
                        verdict_next = VERDICT_NOT_FOUND;
                    end
                    else
                    begin
                        verdict_next = VERDICT_FOUND;
                    end
                    cur_next   = '0;
                    rej_next   = 1'b0;
                    fault_next = 1'b0;
                    term_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            rej_reg        <= 1'b0;
            fault_reg      <= 1'b0;
            term_reg       <= 1'b0;
            last_reg       <= 1'b0;
            table_size_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            rej_reg       <= rej_next;
            fault_reg     <= fault_next;
            term_reg      <= term_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        ch_reg      <= ch_next;
        verdict_reg <= verdict_next;
    end

endmodule

// ----- design/dfalex_checker.sv -----
`timescale 1ns / 1ps

module dfalex_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dfalex_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import dfalex_pkg::*;

    // only the three verdict codes, upper bits zero
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata == M_TDATA_W'(VERDICT_NOT_FOUND))
                       || (m_axis_tdata == M_TDATA_W'(VERDICT_FOUND))
                       || (m_axis_tdata == M_TDATA_W'(VERDICT_ERROR)))
        else $error("invalid verdict code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    // table writes and inner characters never produce a verdict
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && ((op_t'(s_axis_tuser) == OP_WRITE) || !s_axis_tlast)
        |=> !$rose(m_axis_tvalid))
        else $error("verdict issued without a final character");

    // a verdict is issued only while the input side is held off
    a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("verdict issued while input was open");

endmodule

bind dfa_lexicon_word_lookup dfalex_checker u_dfalex_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/dfa_lexicon_word_lookup_tb.sv -----
`timescale 1ns / 1ps

module dfa_lexicon_word_lookup_tb;
    import dfalex_pkg::*;

    localparam int TABLE_DEPTH   = 65536;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 85;
    localparam int MAX_REGION    = 47;
    localparam int NUM_PHASES    = 7;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef enum {ROW_WRITE, ROW_CHAR, ROW_SIZE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] addr;
        logic [31:0] word;
        logic [7:0]  ch;
        bit          last;
        bit          typed;
        verdict_t    verdict;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_wr_en;
    logic [SIZE_W-1:0]      cfg_wr_data;

    // lookup state mirrored by the testbench
    bit [31:0]   dict_mem [TABLE_DEPTH];
    int unsigned walk_pos;
    bit          walk_rejected;
    bit          walk_fault;
    int unsigned size_reg;
    int unsigned region_top;

    verdict_t    pending_verdicts [$];
    verdict_t    head_verdict;
    int          mismatches;
    int          items_sent;
    int unsigned cycle_count;
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          hold_sink;

    dir_row_t    dir_rows [27];
    logic [15:0] size_plan [NUM_PHASES];

    dfa_lexicon_word_lookup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [31:0] trans_word(bit term, logic [7:0] ch, logic [21:0] dest,
                                               bit last);
        return {term, ch, dest, last};
    endfunction

    function automatic bit pos_bad(int unsigned p);
        return (p > size_reg) || (p >= TABLE_DEPTH);
    endfunction

    function automatic void advance_walk(logic [7:0] ch);
        int unsigned p;
        p = dict_mem[walk_pos][22:1];
        if (p == 0)
        begin
            walk_rejected = 1'b1;
            return;
        end
        if (pos_bad(p))
        begin
            walk_fault = 1'b1;
            return;
        end
        while (dict_mem[p][30:23] != ch)
        begin
            if (dict_mem[p][0])
            begin
                walk_rejected = 1'b1;
                return;
            end
            p++;
            if (pos_bad(p))
            begin
                walk_fault = 1'b1;
                return;
            end
        end
        walk_pos = p;
    endfunction

    function automatic bit lookup_step(op_t op, logic [15:0] addr, logic [31:0] word,
                                       logic [7:0] ch, bit last, output verdict_t v);
        v = VERDICT_NOT_FOUND;
        if (op == OP_WRITE)
        begin
            dict_mem[addr] = word;
            return 1'b0;
        end
        if (!walk_rejected && !walk_fault)
            advance_walk(ch);
        if (!last)
            return 1'b0;
        if (walk_fault)
            v = VERDICT_ERROR;
        else if (walk_rejected)
            v = VERDICT_NOT_FOUND;
        else if (dict_mem[walk_pos][31])
            v = VERDICT_FOUND;
        walk_pos      = 0;
        walk_rejected = 1'b0;
        walk_fault    = 1'b0;
        return 1'b1;
    endfunction

    // destinations stay inside the loaded region or beyond table_size,
    // so the block never reads an entry that was not loaded
    function automatic logic [31:0] region_word(int unsigned addr);
        logic [31:0] w;
        int unsigned d;
        int          r;
        w = $urandom;
        r = $urandom_range(0, 9);
        if (r == 0)
            d = 0;
        else if (r == 1)
            d = $urandom_range(size_reg + 1, 32'h3F_FFFF);
        else
            d = (region_top == 0) ? 0 : $urandom_range(1, region_top);
        w[22:1] = d[21:0];
        w[0] = ($urandom_range(0, 2) == 0) || (addr == region_top && size_reg > region_top);
        return w;
    endfunction

    // mostly follows an existing transition so that words go deep
    function automatic logic [7:0] pick_char();
        logic [7:0]  opts [$];
        int unsigned p;
        if (walk_rejected || walk_fault || $urandom_range(0, 6) == 0)
            return 8'($urandom);
        p = dict_mem[walk_pos][22:1];
        while (p != 0 && !pos_bad(p) && opts.size() < 16)
        begin
            opts.push_back(dict_mem[p][30:23]);
            if (dict_mem[p][0])
                break;
            p++;
        end
        if (opts.size() == 0)
            return 8'($urandom);
        return opts[$urandom_range(0, opts.size() - 1)];
    endfunction

    task automatic send_item(op_t op, logic [15:0] addr, logic [31:0] word, logic [7:0] ch,
                             bit last, bit typed, verdict_t typed_v);
        verdict_t v;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {ch, word, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (lookup_step(op, addr, word, ch, last, v))
            pending_verdicts.push_back(typed ? typed_v : v);
    endtask

    task automatic send_char(logic [7:0] ch, bit last);
        send_item(OP_CHAR, 16'($urandom), $urandom, ch, last, 1'b0, VERDICT_NOT_FOUND);
    endtask

    task automatic send_write(logic [15:0] addr, logic [31:0] word);
        send_item(OP_WRITE, addr, word, 8'($urandom), 1'($urandom), 1'b0, VERDICT_NOT_FOUND);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_size(logic [15:0] value);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        size_reg   = value;
        region_top = (size_reg < MAX_REGION) ? size_reg : MAX_REGION;
    endtask

    // output side: random stall bursts, plus one long hold on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall == 0)
            begin
                if (hold_sink)
                begin
                    stall = HOLD_CYCLES;
                    hold_sink = 1'b0;
                end
                else if (sink_idle_on && $urandom_range(0, 5) == 0)
                    stall = $urandom_range(1, 9);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict transaction: tdata 0x%02h", m_axis_tdata);
            end
            else
            begin
                head_verdict = pending_verdicts.pop_front();
                if (m_axis_tdata[1:0] !== head_verdict || m_axis_tdata[7:2] !== 6'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected %0d, got tdata 0x%02h",
                                 head_verdict, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int a;
        int k;
        int len;
        int r;
        int phase_end;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        walk_pos      = 0;
        walk_rejected = 1'b0;
        walk_fault    = 1'b0;
        size_reg      = 0;
        region_top    = 0;
        mismatches    = 0;
        items_sent    = 0;
        cycle_count   = 0;
        hold_sink     = 1'b0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;

        size_plan = '{16'd65535, 16'd30, 16'd3, 16'd0, 16'd1000, 16'd47, 16'd65535};

        // start state at 1: "ab", "b", "ace" found; entry 7 is not marked last
        dir_rows = '{
            '{ROW_WRITE, 16'd0, trans_word(0, 8'h00, 22'd1, 0), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h61, 1, 1, VERDICT_ERROR},
            '{ROW_WRITE, 16'd0, trans_word(0, 8'h00, 22'd0, 0), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'hFF, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h00, 1, 1, VERDICT_NOT_FOUND},
            '{ROW_SIZE,  16'd7, 32'd0, 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd0, trans_word(0, 8'h00, 22'd1, 0), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd1, trans_word(0, 8'h61, 22'd3, 0), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd2, trans_word(1, 8'h62, 22'd0, 1), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd3, trans_word(1, 8'h62, 22'd0, 0), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd4, trans_word(1, 8'h63, 22'd6, 1), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd5, trans_word(0, 8'h78, 22'd0, 1), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd6, trans_word(0, 8'h64, 22'd0, 0), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'd7, trans_word(1, 8'h65, 22'd0, 0), 8'h00, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h61, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h62, 1, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h62, 1, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h61, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h63, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h65, 1, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h61, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h63, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h71, 1, 1, VERDICT_ERROR},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h7A, 1, 1, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h62, 0, 0, VERDICT_NOT_FOUND},
            '{ROW_CHAR,  16'd0, 32'd0, 8'h61, 1, 1, VERDICT_NOT_FOUND},
            '{ROW_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1, 0, VERDICT_NOT_FOUND}
        };

        wait (rst_n);
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_SIZE:
                    load_size(dir_rows[i].addr);
                ROW_WRITE:
                    send_item(OP_WRITE, dir_rows[i].addr, dir_rows[i].word, dir_rows[i].ch,
                              dir_rows[i].last, 1'b0, VERDICT_NOT_FOUND);
                default:
                    send_item(OP_CHAR, dir_rows[i].addr, dir_rows[i].word, dir_rows[i].ch,
                              dir_rows[i].last, dir_rows[i].typed, dir_rows[i].verdict);
            endcase
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            load_size(size_plan[ph]);
            for (a = 0; a <= region_top; a++)
                send_write(a, region_word(a));

            if (ph == 1)
            begin
                hold_sink = 1'b1;
                for (k = 0; k < 30; k++)
                    send_char(pick_char(), 1'b1);
            end

            phase_end = items_sent + PHASE_ITEMS;
            r = 0;
            while (items_sent < phase_end)
            begin
                if (ph == NUM_PHASES - 1)
                begin
                    src_idle_on  = 1'b0;
                    sink_idle_on = 1'b0;
                end
                else if (r % 12 == 0)
                begin
                    src_idle_on  = ($urandom_range(0, 3) != 0);
                    sink_idle_on = ($urandom_range(0, 3) != 0);
                end
                r++;
                case ($urandom_range(0, 19))
                    16, 17:
                    begin
                        a = $urandom_range(0, region_top);
                        send_write(a, region_word(a));
                    end
                    18:
                        send_write($urandom_range(region_top + 1, 65535), $urandom);
                    19:
                        send_char(8'($urandom), 1'($urandom));
                    default:
                    begin
                        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
                        for (k = 0; k < len; k++)
                            send_char(pick_char(), k == len - 1);
                    end
                endcase
            end
        end

        settle_block();
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
